>>> hdl/sorted_list_merge_core_macros.svh
// Assertion helpers shared by the RTL.
`ifndef SORTED_LIST_MERGE_CORE_MACROS_SVH
`define SORTED_LIST_MERGE_CORE_MACROS_SVH

// Clocked check, masked while reset is held.
`define SLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SLM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/slm_pkg.sv
package slm_pkg;

  // Field widths
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 6;

  // Default list capacity
  localparam int LIST_DEPTH_DEF = 32;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_MERGE         = 2'd2
  } slm_cmd_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } slm_state_t;

  // Input item
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
  } slm_in_t;

  // Result item
  typedef struct packed {
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } slm_out_t;

  // Handoff from sequencer to output register
  typedef struct packed {
    logic     emit;
    slm_out_t data;
  } slm_emit_t;

endpackage

>>> hdl/slm_ram.sv
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/slm_ctrl.sv
`include "sorted_list_merge_core_macros.svh"

module slm_ctrl
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  slm_in_t           in_data,
  input  logic              out_free,
  output slm_emit_t         emit_o,
  // first list memory
  output logic              a_we,
  output logic [AW-1:0]     a_waddr,
  output logic              a_re,
  output logic [AW-1:0]     a_raddr,
  input  logic [DATA_W-1:0] a_rdata,
  // second list memory
  output logic              b_we,
  output logic [AW-1:0]     b_waddr,
  output logic              b_re,
  output logic [AW-1:0]     b_raddr,
  input  logic [DATA_W-1:0] b_rdata
);

  localparam int SW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

  slm_state_t    state_r, state_nxt;
  logic [CW-1:0] a_cnt_r, a_cnt_nxt;
  logic [CW-1:0] b_cnt_r, b_cnt_nxt;

  logic          accept;
  logic          start;
  logic          step;
  logic          take_a;
  logic          is_last;
  logic [CW-1:0] a_m1, a_m2, b_m1, b_m2;
  logic [SW-1:0] pos_sum;

  assign accept = in_valid && in_ready;

  // Address arithmetic: head is count-1, the one after it count-2
  assign a_m1 = a_cnt_r - CW'(1);
  assign a_m2 = a_cnt_r - CW'(2);
  assign b_m1 = b_cnt_r - CW'(1);
  assign b_m2 = b_cnt_r - CW'(2);

  // Appends, dropped when the list is full
  assign a_we    = accept && (in_data.command == CMD_APPEND_FIRST)
                   && (a_cnt_r != CW'(LIST_DEPTH));
  assign b_we    = accept && (in_data.command == CMD_APPEND_SECOND)
                   && (b_cnt_r != CW'(LIST_DEPTH));
  assign a_waddr = a_cnt_r[AW-1:0];
  assign b_waddr = b_cnt_r[AW-1:0];

  // Merge start fetches both heads; empty merge does nothing
  assign start = accept && (in_data.command == CMD_MERGE)
                 && ((a_cnt_r != '0) || (b_cnt_r != '0));

  // One element per cycle while the output register can take it
  assign step   = (state_r == ST_MERGE) && out_free;
  assign take_a = (a_cnt_r != '0) &&
                  ((b_cnt_r == '0) || ($signed(a_rdata) >= $signed(b_rdata)));

  assign pos_sum = SW'(a_cnt_r) + SW'(b_cnt_r) - SW'(1);
  assign is_last = (pos_sum == '0);

  // Only the list that advanced fetches its next head
  assign a_re    = start || (step && take_a);
  assign b_re    = start || (step && !take_a);
  assign a_raddr = (state_r == ST_MERGE) ? a_m2[AW-1:0] : a_m1[AW-1:0];
  assign b_raddr = (state_r == ST_MERGE) ? b_m2[AW-1:0] : b_m1[AW-1:0];

  // Counts: grow on append, shrink as the merge consumes them
  always_comb begin
    a_cnt_nxt = a_cnt_r;
    b_cnt_nxt = b_cnt_r;
    if (a_we) begin
      a_cnt_nxt = a_cnt_r + CW'(1);
    end
    if (b_we) begin
      b_cnt_nxt = b_cnt_r + CW'(1);
    end
    if (step) begin
      if (take_a) begin
        a_cnt_nxt = a_m1;
      end else begin
        b_cnt_nxt = b_m1;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (step && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready              = 1'b0;
    emit_o.emit           = 1'b0;
    emit_o.data.position  = pos_sum[POS_W-1:0];
    emit_o.data.element   = take_a ? a_rdata : b_rdata;
    emit_o.data.last      = is_last;
    unique case (state_r)
      ST_IDLE:  in_ready    = 1'b1;
      ST_MERGE: emit_o.emit = step;
      default:  in_ready    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_cnt_r <= '0;
      b_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      a_cnt_r <= a_cnt_nxt;
      b_cnt_r <= b_cnt_nxt;
    end
  end

  // Checks
  `SLM_ASSERT(a_merge_has_work, (state_r == ST_MERGE) |-> ((a_cnt_r != '0) || (b_cnt_r != '0)), "merge running with both lists empty")
  `SLM_ASSERT(a_last_ends_merge, (step && is_last) |=> ((state_r == ST_IDLE) && (a_cnt_r == '0) && (b_cnt_r == '0)), "merge did not end cleanly after last item")
  `SLM_ASSERT(a_cnt_bound, (a_cnt_r <= CW'(LIST_DEPTH)) && (b_cnt_r <= CW'(LIST_DEPTH)), "list count beyond capacity")
  `SLM_ASSERT(a_pos_descends, (step && !is_last) |=> (step |-> (pos_sum == $past(pos_sum) - SW'(1))), "merge positions not descending by one")

endmodule

>>> hdl/sorted_list_merge_core.sv
// Channel   Ports                         Moves
// input     in_valid in_ready in_data     command item (append or merge)
// result    out_valid out_ready out_data  one merged element per item
//
// Appends are taken as they come; the block is ready again the next cycle.
// A merge first fetches both list heads, then emits one element per cycle
// while the result register can take it.
// A stalled result only holds the merge; no input is taken while merging.
// Reset (rst_n, synchronous) clears both counts; list contents need no clearing.
module sorted_list_merge_core
  import slm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  slm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output slm_out_t out_data
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic              out_valid_r;
  slm_out_t          out_data_r;
  logic              out_free;
  slm_emit_t         emit;

  logic              a_we, a_re, b_we, b_re;
  logic [AW-1:0]     a_waddr, a_raddr, b_waddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  assign out_free = !out_valid_r || out_ready;

  slm_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .emit_o   (emit),
    .a_we     (a_we),
    .a_waddr  (a_waddr),
    .a_re     (a_re),
    .a_raddr  (a_raddr),
    .a_rdata  (a_rdata),
    .b_we     (b_we),
    .b_waddr  (b_waddr),
    .b_re     (b_re),
    .b_raddr  (b_raddr),
    .b_rdata  (b_rdata)
  );

  slm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(LIST_DEPTH)
  ) u_first_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_data.value),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  slm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(LIST_DEPTH)
  ) u_second_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (in_data.value),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.emit) begin
      out_data_r <= emit.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> test/merge_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the merge core, keeps its own copy of the two lists,
// works out the merged elements for every accepted item and compares each
// accepted result against the oldest one still outstanding.
module merge_result_checker
  import slm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  slm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  slm_out_t out_data,
  output int       fail_count,
  output int       pending
);

  // Shadow copy of both lists
  logic signed [DATA_W-1:0] first_list [LIST_DEPTH_DEF];
  logic signed [DATA_W-1:0] second_list [LIST_DEPTH_DEF];
  int first_len;
  int second_len;

  // Merged elements still owed by the block, oldest first
  slm_out_t merged_q[$];
  slm_out_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Apply one command to the shadow lists; a merge queues its elements
  task automatic predict_item(input slm_in_t item);
    int a;
    int b;
    slm_out_t res;
    case (item.command)
      CMD_APPEND_FIRST: begin
        // appends to a full list are dropped
        if (first_len < LIST_DEPTH_DEF) begin
          first_list[first_len] = item.value;
          first_len++;
        end
      end
      CMD_APPEND_SECOND: begin
        if (second_len < LIST_DEPTH_DEF) begin
          second_list[second_len] = item.value;
          second_len++;
        end
      end
      CMD_MERGE: begin
        // highest position first; ties go to the first list
        a = first_len;
        b = second_len;
        while (a + b > 0) begin
          res.position = POS_W'(a + b - 1);
          res.last     = (a + b == 1);
          if (a > 0 && (b == 0 || first_list[a-1] >= second_list[b-1])) begin
            res.element = first_list[a-1];
            a--;
          end else begin
            res.element = second_list[b-1];
            b--;
          end
          merged_q.push_back(res);
        end
        first_len  = 0;
        second_len = 0;
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      first_len  = 0;
      second_len = 0;
      merged_q.delete();
    end else begin
      if (in_valid && in_ready)
        predict_item(in_data);
      if (out_valid && out_ready) begin
        if (merged_q.size() == 0) begin
          report_error($sformatf("result with nothing expected: pos %0d elem %0d last %0b",
                                 out_data.position, out_data.element, out_data.last));
        end else begin
          want = merged_q.pop_front();
          if (out_data.position !== want.position)
            report_error($sformatf("position: got %0d, expected %0d",
                                   out_data.position, want.position));
          if (out_data.element !== want.element)
            report_error($sformatf("element at pos %0d: got %0d, expected %0d",
                                   want.position, out_data.element, want.element));
          if (out_data.last !== want.last)
            report_error($sformatf("last at pos %0d: got %0b, expected %0b",
                                   want.position, out_data.last, want.last));
        end
      end
    end
    pending = merged_q.size();
  end

endmodule

>>> test/tb_sorted_list_merge_core.sv
`timescale 1ns / 100ps

module tb_sorted_list_merge_core;
  import slm_pkg::*;

  localparam logic [CMD_W-1:0]        CMD_UNUSED     = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN       = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX       = 32'sh7FFF_FFFF;
  localparam longint                   VAL_MAX_L     = 64'sd2147483647;
  localparam int                       ITEM_GOAL     = 360;
  localparam int                       HOLD_CYCLES   = 200;
  localparam int                       WATCHDOG_LIMIT = 3000;
  localparam int                       DRAIN_CYCLES  = 80;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  slm_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  slm_out_t out_data;

  int fail_count;
  int pending;
  int items_sent;
  int stall_cycles;
  bit steady;
  bit hold_req;
  bit held;

  sorted_list_merge_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  merge_result_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  // Watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item and hold it until taken; may leave a gap afterwards
  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val);
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, value: val};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    if (cmd != CMD_UNUSED)
      items_sent++;
    if (!steady && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic longint start_value(input bit narrow);
    if (narrow)
      return longint'($urandom_range(0, 8)) - 4;
    return longint'($signed($urandom));
  endfunction

  // next ascending value, saturating at the top of the range
  function automatic longint step_up(input longint cur, input bit narrow);
    longint nxt;
    nxt = cur + (narrow ? $urandom_range(0, 2) : $urandom_range(0, 32'h07FF_FFFF));
    return (nxt > VAL_MAX_L) ? VAL_MAX_L : nxt;
  endfunction

  // mostly short lists, now and then up to full depth
  function automatic int pick_len();
    if ($urandom_range(0, 4) == 0)
      return $urandom_range(0, LIST_DEPTH_DEF);
    return $urandom_range(0, 6);
  endfunction

  // Load two ascending lists, appends interleaved at random, some unused codes mixed in
  task automatic load_sorted(input int n_first, input int n_second, input bit narrow);
    longint next_a;
    longint next_b;
    int left_a;
    int left_b;
    left_a = n_first;
    left_b = n_second;
    next_a = start_value(narrow);
    next_b = start_value(narrow);
    while (left_a + left_b > 0) begin
      if ($urandom_range(0, 11) == 0)
        push_item(CMD_UNUSED, $urandom);
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 0)) begin
        push_item(CMD_APPEND_FIRST, next_a[DATA_W-1:0]);
        next_a = step_up(next_a, narrow);
        left_a--;
      end else begin
        push_item(CMD_APPEND_SECOND, next_b[DATA_W-1:0]);
        next_b = step_up(next_b, narrow);
        left_b--;
      end
    end
  endtask

  initial begin
    int pick;
    int seq_idx;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    held       = 1'b0;
    seq_idx    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // merge with both lists empty, then an unused code
    push_item(CMD_MERGE, 0);
    push_item(CMD_UNUSED, VAL_MAX);
    // range extremes, ties across lists
    push_item(CMD_APPEND_FIRST, VAL_MIN);
    push_item(CMD_APPEND_FIRST, -1);
    push_item(CMD_APPEND_FIRST, 0);
    push_item(CMD_APPEND_FIRST, VAL_MAX);
    push_item(CMD_APPEND_SECOND, VAL_MIN);
    push_item(CMD_APPEND_SECOND, 0);
    push_item(CMD_APPEND_SECOND, 0);
    push_item(CMD_APPEND_SECOND, VAL_MAX);
    push_item(CMD_MERGE, -1);
    // only the first list, unsorted
    push_item(CMD_APPEND_FIRST, 5);
    push_item(CMD_APPEND_FIRST, -3);
    push_item(CMD_MERGE, 0);
    // only the second list
    push_item(CMD_APPEND_SECOND, 7);
    push_item(CMD_MERGE, 0);
    // second list unsorted, first with one element, unused code in between
    push_item(CMD_APPEND_SECOND, 3);
    push_item(CMD_APPEND_SECOND, -9);
    push_item(CMD_UNUSED, VAL_MIN);
    push_item(CMD_APPEND_FIRST, 3);
    push_item(CMD_MERGE, 0);

    // Random sequences
    while (items_sent < ITEM_GOAL) begin
      steady = (items_sent >= 150 && items_sent < 230);
      pick = (seq_idx == 0) ? 0 : $urandom_range(0, 99);
      seq_idx++;
      if (pick < 8) begin
        // overfill both lists; the first time, then stall the result side during the merge
        load_sorted($urandom_range(LIST_DEPTH_DEF, LIST_DEPTH_DEF + 4),
                    $urandom_range(LIST_DEPTH_DEF, LIST_DEPTH_DEF + 4),
                    $urandom_range(0, 1) == 0);
        if (!held) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        push_item(CMD_MERGE, $urandom);
      end else if (pick < 75) begin
        load_sorted(pick_len(), pick_len(), $urandom_range(0, 2) == 0);
        push_item(CMD_MERGE, $urandom);
      end else begin
        // noise: any code, any value; the merge is sometimes left out
        repeat ($urandom_range(1, 8))
          push_item(CMD_W'($urandom_range(CMD_APPEND_FIRST, CMD_UNUSED)), $urandom);
        if ($urandom_range(0, 3) != 0)
          push_item(CMD_MERGE, $urandom);
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain outstanding results, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
